[rtl/hss_pkg.sv]
package hss_pkg;

    localparam int SPR_W    = 13;
    localparam int PCT_W    = 16;
    localparam int MAG_W    = 7;
    localparam int DIV_W    = 20;
    localparam int PERIOD_W = 20;
    localparam int COUNT_W  = 19;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 5;
    localparam int MUL_STEPS = MAG_W;
    localparam int DIV_STEPS = DIV_W;

    localparam logic [SPR_W-1:0]   SPR_RESET  = 13'd200;
    localparam logic [MAG_W-1:0]   PCT_LIMIT  = 7'd100;
    localparam logic [COUNT_W-1:0] PERIOD_MAX = 19'd524287;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SPEED = 2'd1,
        OP_POWER = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE = 2'd0,
        MD_MUL  = 2'd1,
        MD_DIV  = 2'd2,
        MD_DONE = 2'd3
    } md_state_t;

    typedef struct packed {
        logic b_enable;
        logic b_phase;
        logic a_enable;
        logic a_phase;
    } pins_t;

    typedef struct packed {
        logic                tick;
        logic                power;
        logic                power_on;
        logic                load;
        logic [PERIOD_W-1:0] period;
    } phase_ctrl_t;

    typedef struct packed {
        pins_t pins;
        logic  stepped;
    } result_t;

    function automatic logic [3:0] drive_mask(input logic [IDX_W-1:0] idx);
        logic [3:0] m;
        case (idx)
            3'd0:    m = 4'hB;
            3'd1:    m = 4'hF;
            3'd2:    m = 4'hE;
            3'd3:    m = 4'hF;
            3'd4:    m = 4'hB;
            3'd5:    m = 4'hF;
            3'd6:    m = 4'hE;
            3'd7:    m = 4'hF;
            default: m = 4'hF;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] drive_level(input logic [IDX_W-1:0] idx);
        logic [3:0] l;
        case (idx)
            3'd0:    l = 4'h3;
            3'd1:    l = 4'hF;
            3'd2:    l = 4'hC;
            3'd3:    l = 4'hE;
            3'd4:    l = 4'h2;
            3'd5:    l = 4'hA;
            3'd6:    l = 4'h8;
            3'd7:    l = 4'hB;
            default: l = 4'h0;
        endcase
        return l;
    endfunction

endpackage

[rtl/hss_muldiv.sv]
module hss_muldiv #(
    parameter int SCALED_TICK_RATE = 300000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hss_pkg::SPR_W-1:0]   spr,
    input  logic [hss_pkg::MAG_W-1:0]   mag,
    output logic                        done,
    output logic [hss_pkg::COUNT_W-1:0] quotient
);
    import hss_pkg::*;

    localparam logic [DIV_W-1:0] RATE_VAL = DIV_W'(SCALED_TICK_RATE);

    md_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAG_W-1:0]  mpl_reg, mpl_next;
    logic [DIV_W-1:0]  mcand_reg, mcand_next;
    logic [DIV_W-1:0]  prod_reg, prod_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  prod_add;
    logic [DIV_W:0]    rem_shift;
    logic              rem_ge;
    logic              last_step;

    assign prod_add  = mpl_reg[0] ? prod_reg + mcand_reg : prod_reg;
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, prod_reg};
    assign last_step = (state_reg == MD_MUL) ? (cnt_reg == CNT_W'(MUL_STEPS - 1))
                                             : (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                    state_next = MD_MUL;
            end
            MD_MUL:
            begin
                if (last_step)
                    state_next = (prod_add == '0) ? MD_DONE : MD_DIV;
            end
            MD_DIV:
            begin
                if (last_step)
                    state_next = MD_DONE;
            end
            MD_DONE:
                state_next = MD_IDLE;
            default:
                state_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        mpl_next   = mpl_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            MD_IDLE:
            begin
                cnt_next   = '0;
                mpl_next   = mag;
                mcand_next = DIV_W'(spr);
                prod_next  = '0;
                rem_next   = '0;
                quo_next   = RATE_VAL;
            end
            MD_MUL:
            begin
                prod_next  = prod_add;
                mcand_next = {mcand_reg[DIV_W-2:0], 1'b0};
                mpl_next   = {1'b0, mpl_reg[MAG_W-1:1]};
                cnt_next   = last_step ? '0 : cnt_reg + 1'b1;
                if (last_step && prod_add == '0)
                    quo_next = '0;
            end
            MD_DIV:
            begin
                rem_next = rem_ge ? DIV_W'(rem_shift - {1'b0, prod_reg})
                                  : rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mpl_reg   <= mpl_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign done     = (state_reg == MD_DONE);
    assign quotient = (quo_reg > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX : quo_reg[COUNT_W-1:0];

endmodule

[rtl/hss_phase.sv]
module hss_phase (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hss_pkg::phase_ctrl_t ctrl,
    output hss_pkg::pins_t       pins_next_out,
    output logic                 stepped
);
    import hss_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [3:0]          pins_reg, pins_next;
    logic [COUNT_W-1:0]  mag;
    logic [3:0]          m;

    assign mag = period_reg[PERIOD_W-1] ? COUNT_W'(-period_reg) : period_reg[COUNT_W-1:0];

    always_comb
    begin
        period_next = period_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pins_next   = pins_reg;
        stepped     = 1'b0;
        m           = '0;
        if (ctrl.tick && period_reg != '0)
        begin
            if (count_reg >= mag)
            begin
                count_next = '0;
                stepped    = 1'b1;
                idx_next   = period_reg[PERIOD_W-1] ? idx_reg + 3'd1 : idx_reg + 3'd7;
                m          = drive_mask(idx_next);
                pins_next  = (pins_reg & ~m) | (drive_level(idx_next) & m);
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (ctrl.power)
            pins_next = ctrl.power_on ? (pins_reg | 4'hA) : (pins_reg & 4'h5);
        if (ctrl.load && ctrl.period != period_reg)
        begin
            period_next = ctrl.period;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            pins_reg   <= '0;
        end
        else
        begin
            period_reg <= period_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pins_reg   <= pins_next;
        end
    end

    assign pins_next_out = pins_t'(pins_next);

endmodule

[rtl/half_step_stepper_sequencer_core.sv]
// Half-step sequencer for a bipolar stepper on two H-bridges. Each request on the
// s_ channel yields one response on m_ carrying the four pin levels after the request
// and a stepped flag. Tick, set-power and unused opcodes are resolved in the accepting
// cycle and the response passes through the result and output registers to m_; no new
// request is taken while the result register is full. A set-speed request holds off
// further requests through a bit-serial shift-add multiply of steps_per_rev by the
// clamped percent magnitude, a restoring divide of SCALED_TICK_RATE, one quotient bit
// per cycle, and a done state; its response then passes through the same two response
// registers. A zero divisor skips the divide. A stalled m_ side adds its stall. One
// response can wait in the output register while the next request is taken.
module half_step_stepper_sequencer_core #(
    parameter int SCALED_TICK_RATE = 300000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // speed_percent[15:0], power_on[16], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // a_phase, a_enable, b_phase, b_enable, stepped, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hss_pkg::*;

    state_t              state_reg, state_next;
    logic [SPR_W-1:0]    spr_reg;
    logic                neg_reg, neg_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic                accept;
    logic                md_start;
    logic                md_done;
    logic [COUNT_W-1:0]  md_quo;
    logic [MAG_W-1:0]    pct_mag;
    logic signed [PCT_W-1:0] pct;
    phase_ctrl_t         ctrl;
    pins_t               pins_next;
    logic                stepped;
    logic                move;
    logic                reg_sel;

    assign pct     = signed'(s_tdata[PCT_W-1:0]);
    assign pct_mag = (pct > signed'(PCT_W'(PCT_LIMIT)) || pct < -signed'(PCT_W'(PCT_LIMIT)))
                     ? PCT_LIMIT : MAG_W'(pct[PCT_W-1] ? -pct : pct);

    assign s_tready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser == OP_SPEED)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (md_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        md_start      = 1'b0;
        ctrl          = '0;
        ctrl.power_on = s_tdata[PCT_W];
        ctrl.period   = neg_reg ? -PERIOD_W'(md_quo) : PERIOD_W'(md_quo);
        neg_next      = neg_reg;
        res_valid_next = res_valid_reg;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_TICK:  ctrl.tick  = 1'b1;
                        OP_POWER: ctrl.power = 1'b1;
                        default:  ctrl.tick  = 1'b0;
                    endcase
                    if (s_tuser == OP_SPEED)
                    begin
                        md_start = 1'b1;
                        neg_next = pct[PCT_W-1];
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{pins: pins_next, stepped: stepped};
                    end
                end
            end
            ST_CALC:
            begin
                if (md_done)
                begin
                    ctrl.load      = 1'b1;
                    res_valid_next = 1'b1;
                    res_next       = '{pins: pins_next, stepped: 1'b0};
                end
            end
            default:
                md_start = 1'b0;
        endcase
        if (move)
            res_valid_next = 1'b0;
    end

    assign move           = res_valid_reg && (!out_valid_reg || m_tready);
    assign out_valid_next = move ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign out_next       = move ? res_reg : out_reg;

    hss_muldiv #(
        .SCALED_TICK_RATE(SCALED_TICK_RATE)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .spr      (spr_reg),
        .mag      (pct_mag),
        .done     (md_done),
        .quotient (md_quo)
    );

    hss_phase u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .pins_next_out (pins_next),
        .stepped       (stepped)
    );

    assign reg_sel = (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spr_reg       <= SPR_RESET;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && reg_sel)
                spr_reg <= pwdata[SPR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign pready   = 1'b1;
    assign prdata   = reg_sel ? {{(32-SPR_W){1'b0}}, spr_reg} : 32'd0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.stepped, out_reg.pins.b_enable, out_reg.pins.b_phase,
                       out_reg.pins.a_enable, out_reg.pins.a_phase};

endmodule

[tb/half_step_sequencer_checker.sv]
module half_step_sequencer_checker #(
    parameter int          TICK_RATE = 300000,
    parameter logic [2:0]  SPR_ADDR  = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hss_pkg::*;

    // half-step table, nibble i = entry i
    localparam logic [31:0] STEP_MASKS  = 32'hFEFB_FEFB;
    localparam logic [31:0] STEP_LEVELS = 32'hB8A2_ECF3;
    localparam longint      PERIOD_LIM  = 524287;

    logic [SPR_W-1:0]           steps_per_rev;
    logic signed [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]         tick_count;
    logic [IDX_W-1:0]           phase_idx;
    logic [3:0]                 pins;
    result_t                    expected_q[$];
    result_t                    want;
    int                         mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic signed [PERIOD_W-1:0] period_for(
        input logic signed [PCT_W-1:0] pct_raw,
        input logic [SPR_W-1:0]        spr
    );
        longint pct;
        longint divisor;
        longint q;
        pct = pct_raw;
        if (pct > 100)
            pct = 100;
        else if (pct < -100)
            pct = -100;
        divisor = longint'(spr) * pct;
        if (divisor == 0)
            return '0;
        q = longint'(TICK_RATE) / divisor;
        if (q > PERIOD_LIM)
            q = PERIOD_LIM;
        else if (q < -PERIOD_LIM)
            q = -PERIOD_LIM;
        return q[PERIOD_W-1:0];
    endfunction

    // advances the sequencer by one request and returns the pin state after it
    function automatic result_t next_pins(
        input logic [1:0]              op,
        input logic signed [PCT_W-1:0] pct,
        input logic                    on
    );
        logic [PERIOD_W-1:0]        mag;
        logic [3:0]                 m;
        logic signed [PERIOD_W-1:0] p;
        result_t                    r;
        r.stepped = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (period != 0) begin
                    mag = (period < 0) ? -period : period;
                    if ({1'b0, tick_count} >= mag) begin
                        tick_count = '0;
                        phase_idx  = (period > 0) ? phase_idx - 1'b1 : phase_idx + 1'b1;
                        m          = STEP_MASKS[phase_idx*4 +: 4];
                        pins       = (pins & ~m) | (STEP_LEVELS[phase_idx*4 +: 4] & m);
                        r.stepped  = 1'b1;
                    end
                    else begin
                        tick_count = tick_count + 1'b1;
                    end
                end
            end
            OP_SPEED:
            begin
                p = period_for(pct, steps_per_rev);
                if (p != period) begin
                    period     = p;
                    tick_count = '0;
                end
            end
            OP_POWER:
            begin
                if (on)
                    pins = pins | 4'hA;
                else
                    pins = pins & 4'h5;
            end
            default:
            begin
            end
        endcase
        r.pins = pins_t'(pins);
        return r;
    endfunction

    task automatic check_field(input string name, input logic exp, input logic got);
        if (exp !== got) begin
            $error("%s: expected %0b, got %0b", name, exp, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            steps_per_rev = SPR_RESET;
            period        = '0;
            tick_count    = '0;
            phase_idx     = '0;
            pins          = '0;
            expected_q.delete();
            pending <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("response with no request outstanding: %h", m_tdata);
                    mismatches++;
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("a_phase", want.pins.a_phase, m_tdata[0]);
                    check_field("a_enable", want.pins.a_enable, m_tdata[1]);
                    check_field("b_phase", want.pins.b_phase, m_tdata[2]);
                    check_field("b_enable", want.pins.b_enable, m_tdata[3]);
                    check_field("stepped", want.stepped, m_tdata[4]);
                end
            end
            if (psel && penable && pwrite && pready && paddr == SPR_ADDR)
                steps_per_rev = pwdata[SPR_W-1:0];
            if (s_tvalid && s_tready)
                expected_q.push_back(next_pins(s_tuser, s_tdata[15:0], s_tdata[16]));
            pending <= expected_q.size();
        end
    end

endmodule

[tb/tb_half_step_stepper_sequencer_core.sv]
module tb_half_step_stepper_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hss_pkg::*;

    localparam int         TICK_RATE    = 300000;
    localparam logic [2:0] ADDR_SPR     = 3'd0;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         PHASES       = 9;
    localparam int         PHASE_ITEMS  = 200;
    localparam int         HOLD_CYCLES  = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // speed_percent[15:0], power_on[16], zero pad
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // a_phase, a_enable, b_phase, b_enable, stepped, zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic        quiet    = 1'b0;
    logic        hold_req = 1'b0;

    always #4 clk = ~clk;

    half_step_stepper_sequencer_core #(
        .SCALED_TICK_RATE(TICK_RATE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    half_step_sequencer_checker #(
        .TICK_RATE (TICK_RATE),
        .SPR_ADDR  (ADDR_SPR)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send(input logic [1:0] op, input logic [15:0] pct, input logic on);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, on, pct};
        do
            @(posedge clk);
        while (!s_tready);
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // response side
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        int          r;
        int          ph;
        int          i;
        logic [1:0]  op;
        logic [15:0] pct;
        logic [12:0] spr;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset steps_per_rev: stopped tick, unused opcode, power, repeated speed
        send(OP_TICK, 16'h0000, 1'b0);
        send(OP_UNUSED, 16'hFFFF, 1'b1);
        send(OP_POWER, 16'h0000, 1'b1);
        send(OP_SPEED, 16'h7FFF, 1'b0);
        send(OP_SPEED, 16'd100, 1'b1);
        send(OP_TICK, 16'hFFFF, 1'b1);
        drain();

        // period of one tick in both directions, clamping, zero speed
        apb_write(ADDR_SPR, 32'd3000);
        send(OP_SPEED, 16'h8000, 1'b0);
        repeat (3) send(OP_TICK, 16'h0000, 1'b0);
        send(OP_SPEED, 16'h7FFF, 1'b1);
        repeat (3) send(OP_TICK, 16'h0000, 1'b0);
        send(OP_SPEED, 16'h0000, 1'b0);
        send(OP_TICK, 16'h0000, 1'b0);
        send(OP_SPEED, 16'd1, 1'b0);
        send(OP_SPEED, 16'hFFFF, 1'b0);
        send(OP_SPEED, 16'd101, 1'b0);
        send(OP_SPEED, -16'sd101, 1'b0);
        send(OP_POWER, 16'hFFFF, 1'b0);
        send(OP_POWER, 16'h0000, 1'b1);
        send(OP_UNUSED, 16'h0000, 1'b0);
        drain();

        // zero steps_per_rev gives a stopped motor
        apb_write(ADDR_SPR, 32'd0);
        send(OP_SPEED, 16'd100, 1'b0);
        send(OP_TICK, 16'h0000, 1'b0);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: spr = 13'd3000;
                1: spr = 13'd8191;
                2: spr = 13'd1500;
                3: spr = 13'd1;
                4: spr = 13'd4096;
                5: spr = 13'($urandom_range(500, 4096));
                6: spr = 13'd0;
                7: spr = 13'd1000;
                default: spr = 13'($urandom_range(1, 8191));
            endcase
            apb_write(ADDR_SPR, {19'd0, spr});
            quiet = (ph % 2 == 0);
            if (ph == 2)
                hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 40)
                    quiet = 1'b0;
                if (ph == 4 && i == PHASE_ITEMS / 2)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 12)
                    op = OP_SPEED;
                else if (r < 20)
                    op = OP_POWER;
                else if (r < 24)
                    op = OP_UNUSED;
                else
                    op = OP_TICK;
                r = $urandom_range(0, 99);
                if (r < 30)
                    pct = 16'($urandom);
                else if (r < 75)
                    pct = 16'($urandom_range(60, 100));
                else
                    pct = 16'($urandom_range(0, 200) - 100);
                if (r >= 30 && r < 75 && $urandom_range(0, 1))
                    pct = -pct;
                send(op, pct, 1'($urandom_range(0, 1)));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/hss_pkg.sv
rtl/hss_muldiv.sv
rtl/hss_phase.sv
rtl/half_step_stepper_sequencer_core.sv
tb/half_step_sequencer_checker.sv
tb/tb_half_step_stepper_sequencer_core.sv
